FILE: hw/rtl/cpsh_pkg.sv
package cpsh_pkg;

  // Field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned HASH_W = 64;
  localparam int unsigned LEN_W  = 11;
  localparam int unsigned VERD_W = 2;

  // FNV-1a 64-bit prime, and an offset basis that differs from the standard FNV-1a value
  localparam logic [HASH_W-1:0] FNV_BASIS = 64'd1469598103934665603;
  localparam logic [HASH_W-1:0] FNV_PRIME = 64'd1099511628211;

  // Screened byte values
  localparam logic [BYTE_W-1:0] BYTE_INT3_LO = 8'hCC;
  localparam logic [BYTE_W-1:0] BYTE_INT_N   = 8'hCD;
  localparam logic [BYTE_W-1:0] BYTE_INTO    = 8'hCE;
  localparam logic [BYTE_W-1:0] BYTE_IRET    = 8'hCF;
  localparam logic [BYTE_W-1:0] BYTE_ESC     = 8'h0F;
  localparam logic [BYTE_W-1:0] BYTE_SYSCALL = 8'h05;
  localparam logic [BYTE_W-1:0] BYTE_RET     = 8'hC3;

  // Verdict codes
  localparam logic [VERD_W-1:0] VERDICT_REJECT = 2'd0;
  localparam logic [VERD_W-1:0] VERDICT_NEW    = 2'd1;
  localparam logic [VERD_W-1:0] VERDICT_DUP    = 2'd2;

  typedef struct packed {
    logic [VERD_W-1:0] verdict;
    logic [HASH_W-1:0] block_hash;
    logic [LEN_W-1:0]  block_length;
  } result_t;

  // One FNV-1a round: xor the byte in, then multiply by the prime.
  // The prime is 2^40 + 0x1B3, so the product is a sum of shifted copies.
  function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                  input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

  function automatic logic is_forbidden(input logic [BYTE_W-1:0] b);
    return (b == BYTE_INT3_LO) || (b == BYTE_INT_N) || (b == BYTE_INTO) ||
           (b == BYTE_IRET);
  endfunction

endpackage

FILE: hw/rtl/cpsh_ifs.sv
interface cpsh_in_if import cpsh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] code_byte;
  logic              is_last;

  modport source (output valid, output code_byte, output is_last, input ready);
  modport sink   (input valid, input code_byte, input is_last, output ready);
endinterface

interface cpsh_out_if import cpsh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VERD_W-1:0] verdict;
  logic [HASH_W-1:0] block_hash;
  logic [LEN_W-1:0]  block_length;

  modport source (output valid, output verdict, output block_hash, output block_length,
                  input ready);
  modport sink   (input valid, input verdict, input block_hash, input block_length,
                  output ready);
endinterface

FILE: hw/rtl/code_patch_screen_and_hash.sv
// Code block screen with a 64-bit hash built from FNV-1a rounds on FNV_BASIS.
// in_bus carries one byte of a candidate code block per item, with is_last
// marking the final byte. out_bus carries one result per block: the verdict
// (rejected, accepted new, duplicate of the last accepted hash), the block's
// hash and its byte count, saturated at MAX_BLOCK_BYTES + 1.
// Throughput: one byte per cycle while in_bus.ready is high, set by the
// hash round, a single shift-and-add step per byte on the running hash register.
// Pipeline: two register stages (input register, then the hash/verdict stage
// into the result register, or into the skid entry while the result register
// holds a result that has not left).
// Output side: a result register plus one skid entry. Bytes keep flowing
// while a result waits; in_bus.ready drops once both entries hold results,
// or once one does while another last byte is in flight and out_bus.ready
// is low.
// Reset (synchronous, rst_n low): running hash returns to FNV_BASIS,
// count, previous byte and reject flag clear, the stored accepted
// hash clears to zero, and no result is pending.
module code_patch_screen_and_hash import cpsh_pkg::*; #(
  parameter int unsigned MAX_BLOCK_BYTES = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  cpsh_in_if.sink       in_bus,
  cpsh_out_if.source    out_bus
);

  localparam int unsigned CNT_W = $clog2(MAX_BLOCK_BYTES + 2);
  localparam int unsigned EXT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_BLOCK_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCK_BYTES);

  // Input register
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;

  // Running block state
  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic [BYTE_W-1:0] prev_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              rej_r, rej_nxt;
  logic [HASH_W-1:0] acc_hash_r;

  // Result register and skid entry
  logic    out_valid_r, skid_valid_r;
  result_t out_r, skid_r, res;
  logic    res_wr;

  logic [EXT_W-1:0] cnt_ext;
  logic             in_acc, out_pop, blk_rej;

  // A pending last byte only blocks input when the held result is not leaving
  assign in_bus.ready = !skid_valid_r && !(out_valid_r && s1_valid_r && s1_last_r && !out_pop);
  assign in_acc       = in_bus.valid && in_bus.ready;
  assign out_pop      = out_valid_r && out_bus.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
    end
    if (in_acc) begin
      s1_byte_r <= in_bus.code_byte;
      s1_last_r <= in_bus.is_last;
    end
  end

  // Hash round, count and screening for the registered byte
  always_comb begin
    hash_nxt = fnv_step(hash_r, s1_byte_r);
    cnt_nxt  = (cnt_r < CNT_SAT) ? cnt_r + 1'b1 : cnt_r;
    rej_nxt  = rej_r || is_forbidden(s1_byte_r) ||
               ((cnt_r != '0) && (prev_r == BYTE_ESC) && (s1_byte_r == BYTE_SYSCALL));
    blk_rej  = rej_nxt || (cnt_nxt > CNT_MAX) || (s1_byte_r != BYTE_RET);
    cnt_ext  = EXT_W'(cnt_nxt);

    res.block_hash   = hash_nxt;
    res.block_length = cnt_ext[LEN_W-1:0];
    if (blk_rej) begin
      res.verdict = VERDICT_REJECT;
    end else if (hash_nxt == acc_hash_r) begin
      res.verdict = VERDICT_DUP;
    end else begin
      res.verdict = VERDICT_NEW;
    end
    res_wr = s1_valid_r && s1_last_r;
  end

  // Running state: cleared after each last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r     <= FNV_BASIS;
      prev_r     <= '0;
      cnt_r      <= '0;
      rej_r      <= 1'b0;
      acc_hash_r <= '0;
    end else if (s1_valid_r) begin
      if (s1_last_r) begin
        hash_r <= FNV_BASIS;
        prev_r <= '0;
        cnt_r  <= '0;
        rej_r  <= 1'b0;
        if (res.verdict == VERDICT_NEW) begin
          acc_hash_r <= hash_nxt;
        end
      end else begin
        hash_r <= hash_nxt;
        prev_r <= s1_byte_r;
        cnt_r  <= cnt_nxt;
        rej_r  <= rej_nxt;
      end
    end
  end

  // Result register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_pop) begin
      if (skid_valid_r) begin
        out_r        <= skid_r;
        skid_valid_r <= res_wr;
        if (res_wr) begin
          skid_r <= res;
        end
      end else begin
        out_valid_r <= res_wr;
        if (res_wr) begin
          out_r <= res;
        end
      end
    end else if (res_wr) begin
      if (!out_valid_r) begin
        out_valid_r <= 1'b1;
        out_r       <= res;
      end else begin
        skid_valid_r <= 1'b1;
        skid_r       <= res;
      end
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.verdict      = out_r.verdict;
  assign out_bus.block_hash   = out_r.block_hash;
  assign out_bus.block_length = out_r.block_length;

endmodule

FILE: test/code_patch_screen_and_hash_test.sv
module code_patch_screen_and_hash_test import cpsh_pkg::*; ;

  localparam int unsigned MAX_BYTES   = 1024;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RAND_ITEMS  = 180;

  typedef logic [BYTE_W-1:0] byte_t;

  // Shapes of random code blocks
  typedef enum {
    KIND_CLEAN,
    KIND_REPEAT,
    KIND_FORBIDDEN,
    KIND_PAIR,
    KIND_BAD_END,
    KIND_TRAIL_ESC
  } block_kind_t;

  // Tracks the running screen/hash state and holds the verdicts still owed.
  class verdict_scoreboard;
    logic [HASH_W-1:0] run_hash;
    byte_t             prev_code;
    int unsigned       run_len;
    bit                run_rejected;
    logic [HASH_W-1:0] last_new_hash;
    result_t           pending_verdicts[$];
    int unsigned       mismatches;

    function new();
      clear_run();
      last_new_hash = '0;
      mismatches    = 0;
    endfunction

    function void clear_run();
      run_hash     = FNV_BASIS;
      prev_code    = '0;
      run_len      = 0;
      run_rejected = 1'b0;
    endfunction

    function int unsigned pending();
      return pending_verdicts.size();
    endfunction

    // Advance the block state by one accepted byte; the last byte owes a verdict.
    function void note_byte(byte_t b, logic last);
      result_t r;
      run_hash = (run_hash ^ {{(HASH_W-BYTE_W){1'b0}}, b}) * FNV_PRIME;
      if (run_len < MAX_BYTES + 1) run_len++;
      if (b >= BYTE_INT3_LO && b <= BYTE_IRET) run_rejected = 1'b1;
      if (run_len > 1 && prev_code == BYTE_ESC && b == BYTE_SYSCALL) run_rejected = 1'b1;
      prev_code = b;
      if (!last) return;
      if (run_len > MAX_BYTES || b != BYTE_RET) run_rejected = 1'b1;
      r.block_hash   = run_hash;
      r.block_length = run_len[LEN_W-1:0];
      if (run_rejected) begin
        r.verdict = VERDICT_REJECT;
      end else if (run_hash == last_new_hash) begin
        r.verdict = VERDICT_DUP;
      end else begin
        r.verdict     = VERDICT_NEW;
        last_new_hash = run_hash;
      end
      pending_verdicts = {pending_verdicts, r};
      clear_run();
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    // Compare one delivered result with the oldest owed verdict.
    task check_verdict(result_t got);
      result_t want;
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("unexpected result verdict=%0d hash=%h len=%0d",
                                  got.verdict, got.block_hash, got.block_length));
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.verdict != want.verdict)
        report_mismatch($sformatf("verdict got %0d want %0d", got.verdict, want.verdict));
      if (got.block_hash != want.block_hash)
        report_mismatch($sformatf("block_hash got %h want %h",
                                  got.block_hash, want.block_hash));
      if (got.block_length != want.block_length)
        report_mismatch($sformatf("block_length got %0d want %0d",
                                  got.block_length, want.block_length));
    endtask

    task report_leftovers();
      foreach (pending_verdicts[i])
        report_mismatch($sformatf("missing result verdict=%0d hash=%h len=%0d",
                                  pending_verdicts[i].verdict,
                                  pending_verdicts[i].block_hash,
                                  pending_verdicts[i].block_length));
    endtask
  endclass

  logic clk;
  logic rst_n = 1'b0;

  cpsh_in_if  in_bus ();
  cpsh_out_if out_bus ();

  code_patch_screen_and_hash #(.MAX_BLOCK_BYTES(MAX_BYTES)) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  verdict_scoreboard verdicts = new();

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_request;
  bit          offering;
  bit          lead_syscall;
  int unsigned random_items;
  byte_t       blk[$];
  byte_t       last_clean[$];

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

  // Result side: check each delivered item, then pick next cycle's ready
  initial begin : result_side
    int unsigned held;
    result_t     got;
    held          = 0;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_bus.valid && out_bus.ready) begin
        got.verdict      = out_bus.verdict;
        got.block_hash   = out_bus.block_hash;
        got.block_length = out_bus.block_length;
        verdicts.check_verdict(got);
      end
      if (hold_request) begin
        out_bus.ready <= 1'b0;
        held++;
        if (held >= HOLD_CYCLES) begin
          hold_request = 1'b0;
          held         = 0;
        end
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic drop_offer();
    if (offering) begin
      in_bus.valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic send_byte(byte_t b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      drop_offer();
      @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.code_byte <= b;
    in_bus.is_last   <= last;
    offering = 1'b1;
    do begin
      @(posedge clk);
    end while (!in_bus.ready);
    verdicts.note_byte(b, last);
  endtask

  task automatic send_block();
    foreach (blk[i]) send_byte(blk[i], i == blk.size() - 1);
  endtask

  task automatic wait_drained();
    drop_offer();
    while (verdicts.pending() != 0) @(posedge clk);
  endtask

  // Random byte that neither trips the forbidden range nor completes a 0F 05 pair
  function automatic byte_t clean_byte(byte_t prev);
    byte_t b;
    do begin
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(2))
          0:       b = BYTE_ESC;
          1:       b = BYTE_SYSCALL;
          default: b = BYTE_RET;
        endcase
      end else begin
        b = byte_t'($urandom_range(255));
      end
    end while ((b >= BYTE_INT3_LO && b <= BYTE_IRET) ||
               (prev == BYTE_ESC && b == BYTE_SYSCALL));
    return b;
  endfunction

  // Fill blk with a block of the given shape
  function automatic void make_block(block_kind_t kind, int unsigned len);
    int unsigned pos;
    byte_t       prev;
    blk.delete();
    if (kind == KIND_REPEAT && last_clean.size() != 0) begin
      blk          = last_clean;
      lead_syscall = 1'b0;
      return;
    end
    prev = '0;
    for (int unsigned i = 0; i < len; i++) begin
      blk  = {blk, clean_byte(prev)};
      prev = blk[i];
    end
    blk[len-1] = BYTE_RET;
    // previous block ended in 0F: start this one with 05, still clean
    if (lead_syscall && len > 1) blk[0] = BYTE_SYSCALL;
    lead_syscall = 1'b0;
    case (kind)
      KIND_FORBIDDEN: blk[$urandom_range(len-1)] = byte_t'(BYTE_INT3_LO + $urandom_range(3));
      KIND_PAIR: begin
        pos = (len < 3) ? 0 : $urandom_range(len-3);
        blk[pos]   = BYTE_ESC;
        blk[pos+1] = BYTE_SYSCALL;
      end
      KIND_BAD_END: begin
        do begin
          blk[len-1] = byte_t'($urandom_range(255));
        end while (blk[len-1] == BYTE_RET);
      end
      KIND_TRAIL_ESC: begin
        blk[len-1]   = BYTE_ESC;
        lead_syscall = 1'b1;
      end
      default: ;
    endcase
    if (kind == KIND_CLEAN) last_clean = blk;
  endfunction

  task automatic random_block();
    int unsigned pick;
    int unsigned len;
    block_kind_t kind;
    pick = $urandom_range(99);
    if (pick < 55)      kind = KIND_CLEAN;
    else if (pick < 65) kind = KIND_REPEAT;
    else if (pick < 73) kind = KIND_FORBIDDEN;
    else if (pick < 81) kind = KIND_PAIR;
    else if (pick < 90) kind = KIND_BAD_END;
    else                kind = KIND_TRAIL_ESC;
    len = ($urandom_range(19) == 0) ? $urandom_range(64, 13) : $urandom_range(12, 1);
    if (kind == KIND_PAIR && len < 2) len = 2;
    make_block(kind, len);
    send_block();
    random_items += blk.size();
  endtask

  // Stimulus
  initial begin
    in_bus.valid     = 1'b0;
    in_bus.code_byte = '0;
    in_bus.is_last   = 1'b0;
    hold_request     = 1'b0;
    offering         = 1'b0;
    lead_syscall     = 1'b0;
    random_items     = 0;
    send_idle_pct    = 19;
    recv_idle_pct    = 61;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: single-byte blocks, duplicate, each forbidden byte, the pair
    // both ways, no pairing across blocks, bad ending, forbidden neighbors
    blk = {BYTE_RET};                        send_block();
    blk = {BYTE_RET};                        send_block();
    blk = {8'h00, 8'hFF, BYTE_RET};          send_block();
    blk = {BYTE_INT3_LO, BYTE_RET};          send_block();
    blk = {BYTE_INT_N, BYTE_RET};            send_block();
    blk = {BYTE_INTO, BYTE_RET};             send_block();
    blk = {BYTE_IRET, BYTE_RET};             send_block();
    blk = {BYTE_ESC, BYTE_SYSCALL, BYTE_RET}; send_block();
    blk = {BYTE_SYSCALL, BYTE_ESC, BYTE_RET}; send_block();
    blk = {BYTE_ESC};                        send_block();
    blk = {BYTE_SYSCALL, BYTE_RET};          send_block();
    blk = {8'hFF};                           send_block();
    blk = {8'hCB, 8'hD0, BYTE_RET};          send_block();
    wait_drained();

    // Random, sender mostly busy, receiver mostly stalled
    while (random_items < RAND_ITEMS / 3) random_block();

    // Long receiver hold-off while bytes keep coming, then a full drain
    hold_request = 1'b1;
    repeat (30) begin
      make_block(KIND_CLEAN, $urandom_range(3, 1));
      send_block();
    end
    wait (!hold_request);
    wait_drained();

    // Roles swapped
    send_idle_pct = 61;
    recv_idle_pct = 19;
    while (random_items < 2 * RAND_ITEMS / 3) random_block();
    wait_drained();

    // Neither side idles
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (random_items < RAND_ITEMS) random_block();

    // Length limit: overlong block whose count saturates before the end
    make_block(KIND_CLEAN, MAX_BYTES + 2); send_block();

    // Drain, then give the output stages time to show any stray item
    drop_offer();
    for (int n = 0; n < 20000 && verdicts.pending() != 0; n++) @(posedge clk);
    repeat (10) @(posedge clk);
    verdicts.report_leftovers();
    if (verdicts.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
